// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define OCA_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define OCA_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

// File: rtl/core/oca_pkg.sv
// Package with the shared types and constants of the ones' complement ALU.
`timescale 1ns / 1ps

package oca_pkg;

	// Width of the operand and result fields on the ports.
	localparam int WORD_W = 64;

	// Default arithmetic width of the core.
	localparam int WIDTH_DEF = 64;

	// Operation codes.
	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_NEG = 3'd2;
	localparam logic [2:0] CMD_ABS = 3'd3;
	localparam logic [2:0] CMD_MUL = 3'd4;
	localparam logic [2:0] CMD_DIV = 3'd5;

	// One input item.
	typedef struct packed {
		logic [2:0]        cmd;
		logic [WORD_W-1:0] operand_a;
		logic [WORD_W-1:0] operand_b;
	} oca_in_t;

	// One result item.
	typedef struct packed {
		logic [WORD_W-1:0] result;
		logic              div_by_zero;
	} oca_out_t;

	// Control from the top level to the engine.
	typedef struct packed {
		logic start;
		logic take;
	} oca_ctrl_t;

	// Status from the engine to the top level.
	typedef struct packed {
		logic idle;
		logic done;
	} oca_stat_t;

endpackage

// File: rtl/core/ones_complement_alu_core.sv
// Top level of the ones' complement ALU: handshakes, engine and output register.
`timescale 1ns / 1ps

// The core takes one item at a time and works it through a single shared
// adder of WIDTH+1 bits under a small sequencer. Negate, abs, the unused
// codes and a divide by plus or minus zero go straight to the done state;
// add and subtract pass a sum step, then an end-around carry step; multiply
// and divide pass one step of the shared adder per bit, then a sign step.
// The result then moves into the output register once that register is free
// or is being read out. The input is ready again as soon as the engine
// has handed its result over, so a new item can be taken while the previous
// result waits in the output register. Operands are reduced to their low
// WIDTH bits and results are zero-extended to the 64-bit field.
module ones_complement_alu_core #(
	parameter int WIDTH = oca_pkg::WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  oca_pkg::oca_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output oca_pkg::oca_out_t out_data
);

	oca_pkg::oca_ctrl_t            ctrl;
	oca_pkg::oca_stat_t            stat;
	logic [oca_pkg::WORD_W-1:0]    res_word;
	logic                          res_err;
	logic                          load;
	logic                          out_valid_q;
	oca_pkg::oca_out_t             out_data_q;

	// Engine control: start on an input transfer, hand over into a free output slot.
	assign in_ready   = stat.idle;
	assign load       = stat.done && (!out_valid_q || out_ready);
	assign ctrl.start = in_valid && in_ready;
	assign ctrl.take  = load;

	oca_engine #(
		.WIDTH(WIDTH)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.item    (in_data),
		.stat    (stat),
		.res_word(res_word),
		.res_err (res_err)
	);

	// Output register holding one finished result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.result      <= res_word;
			out_data_q.div_by_zero <= res_err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/core/oca_engine.sv
// Iterative engine: one shared adder stepped by a small sequencer.
`timescale 1ns / 1ps

module oca_engine #(
	parameter int WIDTH = oca_pkg::WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  oca_pkg::oca_ctrl_t        ctrl,
	input  oca_pkg::oca_in_t          item,
	output oca_pkg::oca_stat_t        stat,
	output logic [oca_pkg::WORD_W-1:0] res_word,
	output logic                      res_err
);

	localparam int CNT_W = $clog2(WIDTH);
	localparam int WORD_W = oca_pkg::WORD_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_SUM,
		ST_ADD_WRAP,
		ST_MUL,
		ST_DIV,
		ST_SIGN,
		ST_DONE
	} state_t;

	// Ones' complement negation: bitwise NOT, but zero stays zero.
	function automatic logic [WIDTH-1:0] oc_neg(input logic [WIDTH-1:0] x);
		oc_neg = (x == '0) ? '0 : ~x;
	endfunction

	state_t           state_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] opx_q;
	logic [WIDTH-1:0] opy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             carry_q;
	logic             neg_q;
	logic             err_q;

	logic [WIDTH-1:0] a_w;
	logic [WIDTH-1:0] b_w;
	logic [WIDTH-1:0] ma;
	logic [WIDTH-1:0] mb;
	logic [WIDTH:0]   add_x;
	logic [WIDTH:0]   add_y;
	logic             add_ci;
	logic [WIDTH+1:0] add_s;
	logic             q_bit;

	// Operands reduced to the core width, and their magnitudes.
	assign a_w = item.operand_a[WIDTH-1:0];
	assign b_w = item.operand_b[WIDTH-1:0];
	assign ma  = a_w[WIDTH-1] ? ~a_w : a_w;
	assign mb  = b_w[WIDTH-1] ? ~b_w : b_w;

	// Operand selection for the shared adder.
	always_comb begin
		add_x  = '0;
		add_y  = '0;
		add_ci = 1'b0;
		case (state_q)
			ST_ADD_SUM: begin
				add_x = {1'b0, acc_q};
				add_y = {1'b0, opy_q};
			end
			ST_ADD_WRAP: begin
				add_x  = {1'b0, acc_q};
				add_ci = carry_q;
			end
			ST_MUL: begin
				add_x = {1'b0, acc_q};
				add_y = opy_q[0] ? {1'b0, opx_q} : '0;
			end
			ST_DIV: begin
				add_x  = {acc_q, opx_q[WIDTH-1]};
				add_y  = ~{1'b0, opy_q};
				add_ci = 1'b1;
			end
			default: begin
				add_ci = 1'b0;
			end
		endcase
	end

	// The shared adder; in a divide step its top bit says the trial fits.
	assign add_s = {1'b0, add_x} + {1'b0, add_y} + {{(WIDTH+1){1'b0}}, add_ci};
	assign q_bit = add_s[WIDTH+1];

	// Sequencer with its working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			opx_q   <= '0;
			opy_q   <= '0;
			cnt_q   <= '0;
			carry_q <= 1'b0;
			neg_q   <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						err_q <= 1'b0;
						neg_q <= a_w[WIDTH-1] ^ b_w[WIDTH-1];
						cnt_q <= CNT_W'(WIDTH - 1);
						case (item.cmd)
							oca_pkg::CMD_ADD: begin
								acc_q   <= a_w;
								opy_q   <= b_w;
								state_q <= ST_ADD_SUM;
							end
							oca_pkg::CMD_SUB: begin
								acc_q   <= a_w;
								opy_q   <= oc_neg(b_w);
								state_q <= ST_ADD_SUM;
							end
							oca_pkg::CMD_NEG: begin
								acc_q   <= oc_neg(a_w);
								state_q <= ST_DONE;
							end
							oca_pkg::CMD_ABS: begin
								acc_q   <= ma;
								state_q <= ST_DONE;
							end
							oca_pkg::CMD_MUL: begin
								acc_q   <= '0;
								opx_q   <= ma;
								opy_q   <= mb;
								state_q <= ST_MUL;
							end
							oca_pkg::CMD_DIV: begin
								acc_q <= '0;
								opx_q <= ma;
								opy_q <= mb;
								if (mb == '0) begin
									err_q   <= 1'b1;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_DIV;
								end
							end
							default: begin
								acc_q   <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_ADD_SUM: begin
					acc_q   <= add_s[WIDTH-1:0];
					carry_q <= add_s[WIDTH];
					state_q <= ST_ADD_WRAP;
				end
				ST_ADD_WRAP: begin
					// Negative zero after the end-around carry becomes plus zero.
					acc_q   <= (&add_s[WIDTH-1:0]) ? '0 : add_s[WIDTH-1:0];
					state_q <= ST_DONE;
				end
				ST_MUL: begin
					acc_q <= add_s[WIDTH-1:0];
					opx_q <= {opx_q[WIDTH-2:0], 1'b0};
					opy_q <= {1'b0, opy_q[WIDTH-1:1]};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_SIGN;
					end
				end
				ST_DIV: begin
					// Restoring step: the quotient bit shifts into the dividend register.
					opx_q <= {opx_q[WIDTH-2:0], q_bit};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						acc_q   <= {opx_q[WIDTH-2:0], q_bit};
						state_q <= ST_SIGN;
					end else if (q_bit) begin
						acc_q <= add_s[WIDTH-1:0];
					end else begin
						acc_q <= {acc_q[WIDTH-2:0], opx_q[WIDTH-1]};
					end
				end
				ST_SIGN: begin
					acc_q   <= neg_q ? oc_neg(acc_q) : acc_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ctrl.take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Status and result towards the top level.
	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign res_word  = WORD_W'(acc_q);
	assign res_err   = err_q;

endmodule

// File: rtl/core/oca_checker.sv
// Port-level checker for the ones' complement ALU, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module oca_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input oca_pkg::oca_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input oca_pkg::oca_out_t out_data
);

	// A stalled result must hold still.
	`OCA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

	// The core is busy in the cycle after it takes an item.
	`OCA_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready, "input still ready after a transfer")

	// A divide error always comes with a zero result word.
	`OCA_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && out_data.div_by_zero, out_data.result == '0, "divide error with non-zero result")

	// A transfer of any item with operand_b of plus zero, not only a divide, cannot be taken back-to-back with readiness.
	`OCA_ASSERT_NXT(a_div_zero_busy, clk, arst_n, in_valid && in_ready && (in_data.operand_b == '0), !in_ready, "input ready right after a zero-divisor item")

endmodule

bind ones_complement_alu_core oca_checker u_oca_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for the ones' complement ALU core.
`timescale 1ns / 1ps

module tb;
	import oca_pkg::*;

	// Command codes that the package leaves unassigned.
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
	localparam logic [WORD_W-1:0] MAX_POS  = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] MIN_NEG  = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] QUARTER  = {2'b01, {(WORD_W-2){1'b0}}};

	localparam int RANDOM_ITEMS   = 625;
	localparam int TAIL_CYCLES    = 100;
	localparam int WATCHDOG_LIMIT = 2000;

	// One row of the directed part; want is used only where typed is set.
	typedef struct {
		oca_in_t  item;
		bit       typed;
		oca_out_t want;
	} stim_row_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	oca_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	oca_out_t out_data;

	// Side information that travels with the item on the input channel.
	bit       row_typed;
	oca_out_t row_want;

	oca_out_t  results_due[$];
	stim_row_t directed[$];
	int        mismatches = 0;
	int        quiet_cycles = 0;
	bit        no_idle = 1'b0;

	ones_complement_alu_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// Ones' complement negation: bitwise NOT, but plus zero stays plus zero.
	function automatic logic [WORD_W-1:0] ones_negate(input logic [WORD_W-1:0] x);
		return (x == '0) ? '0 : ~x;
	endfunction

	function automatic logic [WORD_W-1:0] ones_magnitude(input logic [WORD_W-1:0] x);
		return x[WORD_W-1] ? ones_negate(x) : x;
	endfunction

	// Sum with end-around carry; negative zero folds to plus zero.
	function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0]   sum;
		logic [WORD_W-1:0] folded;
		sum = {1'b0, a} + {1'b0, b};
		folded = sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, sum[WORD_W]};
		return (folded == ALL_ONES) ? '0 : folded;
	endfunction

	// Expected result of one input transfer.
	function automatic oca_out_t alu_predict(input oca_in_t it);
		oca_out_t          r;
		logic [WORD_W-1:0] ma;
		logic [WORD_W-1:0] mb;
		logic [WORD_W-1:0] mag;
		logic              signs_differ;
		r = '0;
		ma = ones_magnitude(it.operand_a);
		mb = ones_magnitude(it.operand_b);
		signs_differ = it.operand_a[WORD_W-1] ^ it.operand_b[WORD_W-1];
		case (it.cmd)
			CMD_ADD: r.result = ones_add(it.operand_a, it.operand_b);
			CMD_SUB: r.result = ones_add(it.operand_a, ones_negate(it.operand_b));
			CMD_NEG: r.result = ones_negate(it.operand_a);
			CMD_ABS: r.result = ma;
			CMD_MUL: begin
				mag = ma * mb;
				r.result = signs_differ ? ones_negate(mag) : mag;
			end
			CMD_DIV: begin
				if (mb == '0) begin
					r.div_by_zero = 1'b1;
				end else begin
					mag = ma / mb;
					r.result = signs_differ ? ones_negate(mag) : mag;
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [WORD_W-1:0] full_word();
		return {$urandom, $urandom};
	endfunction

	// Operand with a bias towards zeros, sign extremes and small values.
	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] w;
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = ALL_ONES;
			2: w = MAX_POS;
			3: w = MIN_NEG;
			4: w = WORD_W'($urandom_range(1, 255));
			5: w = ~WORD_W'($urandom_range(1, 255));
			6: w = WORD_W'($urandom);
			7: w = ~WORD_W'($urandom);
			default: w = full_word();
		endcase
		return w;
	endfunction

	// Operand whose magnitude fits in 32 bits, of either sign.
	function automatic logic [WORD_W-1:0] narrow_word();
		logic [WORD_W-1:0] w;
		w = WORD_W'($urandom >> $urandom_range(0, 31));
		return $urandom_range(0, 1) ? ~w : w;
	endfunction

	task automatic put_row(input logic [2:0] cmd, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input bit typed,
			input logic [WORD_W-1:0] res, input logic err);
		stim_row_t row;
		row.item.cmd = cmd;
		row.item.operand_a = a;
		row.item.operand_b = b;
		row.typed = typed;
		row.want.result = res;
		row.want.div_by_zero = err;
		directed.push_back(row);
	endtask

	// Present one item after a random gap and hold it until the transfer.
	task automatic send_item(input oca_in_t item, input bit typed, input oca_out_t want);
		int n;
		n = pick_gap();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (!(in_valid && in_ready))
			@(posedge clk);
		@(negedge clk);
	endtask

	// Result side: random stalls that start on any cycle.
	initial begin : sink
		int hold;
		hold = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0)
					hold = pick_gap();
			end
		end
	end

	// Records accepted items, checks results in order and guards against a hang.
	always @(posedge clk) begin : monitor
		oca_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				results_due.push_back(row_typed ? row_want : alu_predict(in_data));
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, actual result %h div_by_zero %b",
						$time, out_data.result, out_data.div_by_zero);
				end else begin
					want = results_due.pop_front();
					if (out_data.result !== want.result) begin
						mismatches++;
						$display("%0t: result mismatch, expected %h actual %h",
							$time, want.result, out_data.result);
					end
					if (out_data.div_by_zero !== want.div_by_zero) begin
						mismatches++;
						$display("%0t: div_by_zero mismatch, expected %b actual %b",
							$time, want.div_by_zero, out_data.div_by_zero);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : main
		oca_in_t item;
		int      r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		row_typed = 1'b0;
		row_want = '0;

		// Directed rows: extremes, every command, negative zero and zero divisors.
		put_row(CMD_ADD, '0, '0, 1, '0, 0);
		put_row(CMD_ADD, ALL_ONES, ALL_ONES, 1, '0, 0);
		put_row(CMD_ADD, MAX_POS, MAX_POS, 0, '0, 0);
		put_row(CMD_ADD, 64'd1, ~64'd1, 1, '0, 0);
		put_row(CMD_ADD, MIN_NEG, MIN_NEG, 0, '0, 0);
		put_row(CMD_SUB, 64'd5, 64'd5, 1, '0, 0);
		put_row(CMD_SUB, '0, '0, 1, '0, 0);
		put_row(CMD_SUB, MIN_NEG, MAX_POS, 0, '0, 0);
		put_row(CMD_NEG, '0, full_word(), 1, '0, 0);
		put_row(CMD_NEG, ALL_ONES, full_word(), 1, '0, 0);
		put_row(CMD_NEG, MAX_POS, full_word(), 1, MIN_NEG, 0);
		put_row(CMD_NEG, MIN_NEG, full_word(), 1, MAX_POS, 0);
		put_row(CMD_ABS, MIN_NEG, full_word(), 1, MAX_POS, 0);
		put_row(CMD_ABS, MAX_POS, full_word(), 1, MAX_POS, 0);
		put_row(CMD_ABS, ALL_ONES, full_word(), 1, '0, 0);
		put_row(CMD_MUL, MAX_POS, MAX_POS, 0, '0, 0);
		put_row(CMD_MUL, 64'd3, ~64'd5, 0, '0, 0);
		put_row(CMD_MUL, ALL_ONES, 64'd12345, 0, '0, 0);
		put_row(CMD_MUL, QUARTER, 64'd2, 0, '0, 0);
		put_row(CMD_DIV, 64'd100, 64'd7, 0, '0, 0);
		put_row(CMD_DIV, 64'd5, '0, 1, '0, 1);
		put_row(CMD_DIV, 64'd5, ALL_ONES, 1, '0, 1);
		put_row(CMD_DIV, MAX_POS, 64'd1, 1, MAX_POS, 0);
		put_row(CMD_SPARE_6, full_word(), full_word(), 1, '0, 0);
		put_row(CMD_SPARE_7, full_word(), full_word(), 1, '0, 0);

		// Reset once, then release between edges.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[k])
			send_item(directed[k].item, directed[k].typed, directed[k].want);

		// Random part, with two stretches free of idling and one drain pause.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			no_idle = (k >= 100 && k < 180) || (k >= 450 && k < 520);
			if (k == 300) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (results_due.size() != 0)
					@(negedge clk);
			end
			r = $urandom_range(0, 99);
			item.operand_a = pick_word();
			item.operand_b = pick_word();
			if (r < 15) begin
				item.cmd = CMD_ADD;
			end else if (r < 30) begin
				item.cmd = CMD_SUB;
			end else if (r < 40) begin
				item.cmd = CMD_NEG;
				item.operand_b = full_word();
			end else if (r < 50) begin
				item.cmd = CMD_ABS;
				item.operand_b = full_word();
			end else if (r < 72) begin
				item.cmd = CMD_MUL;
				if ($urandom_range(0, 9) < 6) begin
					item.operand_a = narrow_word();
					item.operand_b = narrow_word();
				end
			end else if (r < 96) begin
				item.cmd = CMD_DIV;
				case ($urandom_range(0, 19))
					0: item.operand_b = '0;
					1: item.operand_b = ALL_ONES;
					2, 3, 4, 5, 6, 7: item.operand_b = narrow_word();
					default: item.operand_b = pick_word();
				endcase
			end else begin
				item.cmd = (r < 98) ? CMD_SPARE_6 : CMD_SPARE_7;
				item.operand_a = full_word();
				item.operand_b = full_word();
			end
			send_item(item, 1'b0, '0);
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		// Drain, then watch a while longer for stray results.
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/oca_pkg.sv
rtl/core/oca_engine.sv
rtl/core/ones_complement_alu_core.sv
rtl/core/oca_checker.sv
dv/tb.sv
